// ===== rtl/dibp_pkg.sv =====
// Shared constants and register indexes for the depth back-projection pipeline.
// Used by dibp_blend and the top level; depends on nothing.
package dibp_pkg;

	// fixed field widths
	localparam int POS_W    = 20;
	localparam int SAMPLE_W = 16;
	localparam int CFG_W    = 20;
	localparam int SCALE_W  = 16;
	localparam int OUT_W    = 32;
	localparam int IDX_W    = 3;

	// weight is floor(2^30 / (d2 + 1)), so it fits 31 bits
	localparam int WEIGHT_W     = 31;
	localparam int WEIGHT_SHIFT = 30;

	// fraction bits of a depth in metres
	localparam int Z_FRAC = 16;

	// default parameter values
	localparam int COORD_FRAC_BITS_DEF = 8;
	localparam int DEPTH_BITS_DEF      = 16;

	// register indexes on the configuration port
	localparam logic [IDX_W-1:0] REG_FOCAL_X     = 3'd0;
	localparam logic [IDX_W-1:0] REG_FOCAL_Y     = 3'd1;
	localparam logic [IDX_W-1:0] REG_CENTER_X    = 3'd2;
	localparam logic [IDX_W-1:0] REG_CENTER_Y    = 3'd3;
	localparam logic [IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;

	// register reset values
	localparam logic [CFG_W-1:0]   FOCAL_X_RST     = 20'd153600;
	localparam logic [CFG_W-1:0]   FOCAL_Y_RST     = 20'd153600;
	localparam logic [CFG_W-1:0]   CENTER_X_RST    = 20'd81920;
	localparam logic [CFG_W-1:0]   CENTER_Y_RST    = 20'd61440;
	localparam logic [SCALE_W-1:0] DEPTH_SCALE_RST = 16'd1000;

endpackage

// ===== rtl/dibp_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage, several lanes.
// Caller keeps dividend >> QW below the divisor. Uses nothing from the package.
module dibp_div #(
	parameter int LANES = 1,
	parameter int NW    = 2,
	parameter int DW    = 2,
	parameter int QW    = 2,
	parameter int SW    = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [LANES-1:0][NW-1:0]    dividend,
	input  logic [LANES-1:0][DW-1:0]    divisor,
	input  logic [SW-1:0]               side_in,
	output logic                        out_valid,
	output logic [LANES-1:0][QW-1:0]    quotient,
	output logic [SW-1:0]               side_out
);

	// stage registers, stage k holds k quotient bits
	logic [QW:1]                   vld_s;
	logic [LANES-1:0][DW-1:0]      rem_s  [1:QW];
	logic [LANES-1:0][QW-1:0]      low_s  [1:QW];
	logic [LANES-1:0][QW-1:0]      quo_s  [1:QW];
	logic [LANES-1:0][DW-1:0]      dvs_s  [1:QW];
	logic [SW-1:0]                 side_s [1:QW];

	// inputs of each step
	logic [LANES-1:0][DW-1:0]      st_rem [0:QW-1];
	logic [LANES-1:0][QW-1:0]      st_low [0:QW-1];
	logic [LANES-1:0][QW-1:0]      st_quo [0:QW-1];
	logic [LANES-1:0][DW-1:0]      st_dvs [0:QW-1];
	logic [SW-1:0]                 st_side[0:QW-1];
	logic [LANES-1:0][DW:0]        trial  [0:QW-1];
	logic [LANES-1:0][DW:0]        shifted[0:QW-1];

	// gather step inputs: the first step reads the ports
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			st_rem[0][l] = DW'(dividend[l] >> QW);
			st_low[0][l] = dividend[l][QW-1:0];
			st_quo[0][l] = '0;
			st_dvs[0][l] = divisor[l];
		end
		st_side[0] = side_in;
		for (int k = 1; k < QW; k++) begin
			st_rem[k]  = rem_s[k];
			st_low[k]  = low_s[k];
			st_quo[k]  = quo_s[k];
			st_dvs[k]  = dvs_s[k];
			st_side[k] = side_s[k];
		end
		for (int k = 0; k < QW; k++) begin
			for (int l = 0; l < LANES; l++) begin
				shifted[k][l] = {st_rem[k][l], st_low[k][l][QW-1]};
				trial[k][l]   = shifted[k][l] - {1'b0, st_dvs[k][l]};
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[QW-1:1], in_valid};
		end
	end

	// one compare and subtract per stage
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				for (int l = 0; l < LANES; l++) begin
					rem_s[k+1][l] <= trial[k][l][DW] ? shifted[k][l][DW-1:0]
					                                  : trial[k][l][DW-1:0];
					low_s[k+1][l] <= {st_low[k][l][QW-2:0], 1'b0};
					quo_s[k+1][l] <= {st_quo[k][l][QW-2:0], ~trial[k][l][DW]};
					dvs_s[k+1][l] <= st_dvs[k][l];
				end
				side_s[k+1] <= st_side[k];
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign quotient  = quo_s[QW];
	assign side_out  = side_s[QW];

endmodule

// ===== rtl/dibp_blend.sv =====
// Weighted blend of four depth samples: products, sums, scale and rounding bias.
// Depends on dibp_pkg; feeds the depth divider.
module dibp_blend #(
	parameter int DB = dibp_pkg::DEPTH_BITS_DEF,
	parameter int SW = 1,
	localparam int PW   = dibp_pkg::WEIGHT_W + DB,
	localparam int NUMW = PW + 2,
	localparam int WSW  = dibp_pkg::WEIGHT_W + 2,
	localparam int DENW = WSW + dibp_pkg::SCALE_W,
	localparam int ZNW  = NUMW + dibp_pkg::Z_FRAC + 1
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   en,
	input  logic                                   in_valid,
	input  logic [3:0][dibp_pkg::WEIGHT_W-1:0]     weight,
	input  logic [3:0][DB-1:0]                     sample,
	input  logic [3:0]                             present,
	input  logic [dibp_pkg::SCALE_W-1:0]           scale,
	input  logic [SW-1:0]                          side_in,
	output logic                                   out_valid,
	output logic [ZNW-1:0]                         dividend,
	output logic [DENW-1:0]                        divisor,
	output logic [SW-1:0]                          side_out
);

	logic [4:1]                            vld_s;
	logic [3:0][PW-1:0]                    prod_s1;
	logic [3:0][dibp_pkg::WEIGHT_W-1:0]    wgt_s1;
	logic [SW-1:0]                         side_s1;
	logic [NUMW-1:0]                       num_s2;
	logic [WSW-1:0]                        wsum_s2;
	logic [SW-1:0]                         side_s2;
	logic [NUMW-1:0]                       num_s3;
	logic [DENW-1:0]                       den_s3;
	logic [SW-1:0]                         side_s3;
	logic [ZNW-1:0]                        zn_s4;
	logic [DENW-1:0]                       den_s4;
	logic [SW-1:0]                         side_s4;

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[3:1], in_valid};
		end
	end

	// weight times sample, drop absent samples; sum; scale; add rounding half
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				prod_s1[i] <= present[i] ? PW'(weight[i]) * PW'(sample[i]) : '0;
				wgt_s1[i]  <= present[i] ? weight[i] : '0;
			end
			side_s1 <= side_in;

			num_s2  <= NUMW'(prod_s1[0]) + NUMW'(prod_s1[1])
			         + NUMW'(prod_s1[2]) + NUMW'(prod_s1[3]);
			wsum_s2 <= WSW'(wgt_s1[0]) + WSW'(wgt_s1[1])
			         + WSW'(wgt_s1[2]) + WSW'(wgt_s1[3]);
			side_s2 <= side_s1;

			num_s3  <= num_s2;
			den_s3  <= DENW'(wsum_s2) * DENW'(scale);
			side_s3 <= side_s2;

			zn_s4   <= (ZNW'(num_s3) << dibp_pkg::Z_FRAC) + ZNW'(den_s3 >> 1);
			den_s4  <= den_s3;
			side_s4 <= side_s3;
		end
	end

	assign out_valid = vld_s[4];
	assign dividend  = zn_s4;
	assign divisor   = den_s4;
	assign side_out  = side_s4;

endmodule

// ===== rtl/depth_interp_backprojection.sv =====
// Depth blend and pinhole back-projection, top level.
// One beat is accepted per cycle while the output beat is not held.
// The pipeline holds three bit-per-stage dividers (weights 31, depth 32, X/Y 32 stages);
// a held output beat stalls every stage together, so nothing is lost or repeated.
// arst_n clears valid bits and loads the intrinsics and depth scale reset values.
// Depends on dibp_pkg, dibp_div and dibp_blend.
module depth_interp_backprojection #(
	parameter int COORD_FRAC_BITS = dibp_pkg::COORD_FRAC_BITS_DEF,
	parameter int DEPTH_BITS      = dibp_pkg::DEPTH_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration writes
	input  logic                          cfg_we,
	input  logic [dibp_pkg::IDX_W-1:0]    cfg_index,
	input  logic [dibp_pkg::CFG_W-1:0]    cfg_data,
	// input beats
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [103:0]                  s_axis_tdata,  // pos_x, pos_y, depth_ul, depth_ll,
	                                                     // depth_lr, depth_ur
	// result beats
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [95:0]                   m_axis_tdata,  // point_x, point_y, point_z
	output logic                          m_axis_tuser   // no_depth
);

	localparam int F     = COORD_FRAC_BITS;
	localparam int DB    = DEPTH_BITS;
	localparam int PW_   = dibp_pkg::POS_W;
	localparam int D2W   = 2 * F + 2;
	localparam int NUMW  = dibp_pkg::WEIGHT_W + DB + 2;
	localparam int DENW  = dibp_pkg::WEIGHT_W + 2 + dibp_pkg::SCALE_W;
	localparam int ZNW   = NUMW + dibp_pkg::Z_FRAC + 1;
	localparam int OW    = dibp_pkg::OUT_W;
	localparam int NXW   = PW_ + OW + 1;
	localparam int SIDEA = 2 * (PW_ + 1);
	localparam int SIDE1 = 4 * DB + 4 + SIDEA;
	localparam int SIDE2 = SIDEA + 1;
	localparam int SIDE3 = OW + 5;
	localparam logic [F:0] ONE = (F+1)'(1) << F;
	localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] NEG_MAX = {1'b1, {(OW-1){1'b0}}};

	// configuration registers
	logic [dibp_pkg::CFG_W-1:0]   focal_x_q, focal_y_q, center_x_q, center_y_q;
	logic [dibp_pkg::SCALE_W-1:0] depth_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q     <= dibp_pkg::FOCAL_X_RST;
			focal_y_q     <= dibp_pkg::FOCAL_Y_RST;
			center_x_q    <= dibp_pkg::CENTER_X_RST;
			center_y_q    <= dibp_pkg::CENTER_Y_RST;
			depth_scale_q <= dibp_pkg::DEPTH_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				dibp_pkg::REG_FOCAL_X:     focal_x_q  <= cfg_data;
				dibp_pkg::REG_FOCAL_Y:     focal_y_q  <= cfg_data;
				dibp_pkg::REG_CENTER_X:    center_x_q <= cfg_data;
				dibp_pkg::REG_CENTER_Y:    center_y_q <= cfg_data;
				dibp_pkg::REG_DEPTH_SCALE:
					depth_scale_q <= cfg_data[dibp_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// zero focal lengths and scale count as one
	logic [dibp_pkg::CFG_W-1:0]   fx_eff, fy_eff;
	logic [dibp_pkg::SCALE_W-1:0] scale_eff;
	assign fx_eff    = (focal_x_q == '0) ? dibp_pkg::CFG_W'(1) : focal_x_q;
	assign fy_eff    = (focal_y_q == '0) ? dibp_pkg::CFG_W'(1) : focal_y_q;
	assign scale_eff = (depth_scale_q == '0) ? dibp_pkg::SCALE_W'(1) : depth_scale_q;

	// whole pipeline moves when the output register can take a beat
	logic adv;
	logic m_valid_q;
	assign adv           = ~m_valid_q | m_axis_tready;
	assign s_axis_tready = adv;

	// unpack the input beat
	logic [PW_-1:0]     px, py;
	logic [3:0][DB-1:0] smp;
	logic [F-1:0]       frx, fry;
	logic [F:0]         clx, cly;
	logic [D2W-1:0]     d2_c [4];
	assign px     = s_axis_tdata[19:0];
	assign py     = s_axis_tdata[39:20];
	assign smp[0] = s_axis_tdata[40 +: DB];
	assign smp[1] = s_axis_tdata[56 +: DB];
	assign smp[2] = s_axis_tdata[72 +: DB];
	assign smp[3] = s_axis_tdata[88 +: DB];
	assign frx    = px[F-1:0];
	assign fry    = py[F-1:0];
	assign clx    = (frx == '0) ? '0 : ONE - (F+1)'(frx);
	assign cly    = (fry == '0) ? '0 : ONE - (F+1)'(fry);

	// squared distances plus one, neighbour order ul, ll, lr, ur
	always_comb begin
		d2_c[0] = D2W'(frx) * D2W'(frx) + D2W'(fry) * D2W'(fry) + D2W'(1);
		d2_c[1] = D2W'(frx) * D2W'(frx) + D2W'(cly) * D2W'(cly) + D2W'(1);
		d2_c[2] = D2W'(clx) * D2W'(clx) + D2W'(cly) * D2W'(cly) + D2W'(1);
		d2_c[3] = D2W'(clx) * D2W'(clx) + D2W'(fry) * D2W'(fry) + D2W'(1);
	end

	// stage A: distances, presence and offsets from the principal point
	logic                    vld_a_s1;
	logic [3:0][D2W-1:0]     d2_a_s1;
	logic [3:0][DB-1:0]      smp_a_s1;
	logic [3:0]              pres_a_s1;
	logic [PW_-1:0]          dx_a_s1, dy_a_s1;
	logic                    nx_a_s1, ny_a_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_s1 <= 1'b0;
		end else if (adv) begin
			vld_a_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				d2_a_s1[i]   <= d2_c[i];
				smp_a_s1[i]  <= smp[i];
				pres_a_s1[i] <= (smp[i] != '0);
			end
			nx_a_s1 <= px < center_x_q;
			ny_a_s1 <= py < center_y_q;
			dx_a_s1 <= (px < center_x_q) ? center_x_q - px : px - center_x_q;
			dy_a_s1 <= (py < center_y_q) ? center_y_q - py : py - center_y_q;
		end
	end

	// weight divider: 2^30 / (d2 + 1) for four neighbours
	logic [3:0][dibp_pkg::WEIGHT_W-1:0] w_num;
	logic [3:0][dibp_pkg::WEIGHT_W-1:0] w_q;
	logic [SIDE1-1:0]                   w_side_in, w_side_out;
	logic                               w_vld;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			w_num[i] = dibp_pkg::WEIGHT_W'(1) << dibp_pkg::WEIGHT_SHIFT;
		end
	end
	assign w_side_in = {smp_a_s1, pres_a_s1, nx_a_s1, dx_a_s1, ny_a_s1, dy_a_s1};

	dibp_div #(
		.LANES(4), .NW(dibp_pkg::WEIGHT_W), .DW(D2W), .QW(dibp_pkg::WEIGHT_W), .SW(SIDE1)
	) u_wdiv (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_a_s1),
		.dividend(w_num), .divisor(d2_a_s1), .side_in(w_side_in),
		.out_valid(w_vld), .quotient(w_q), .side_out(w_side_out)
	);

	// blend
	logic [3:0][DB-1:0] b_smp;
	logic [3:0]         b_pres;
	logic [SIDEA-1:0]   b_geo;
	logic [SIDE2-1:0]   b_side_in, b_side_out;
	logic [ZNW-1:0]     z_num;
	logic [DENW-1:0]    z_den;
	logic               b_vld;
	assign {b_smp, b_pres, b_geo} = w_side_out;
	assign b_side_in = {b_geo, (b_pres == 4'b0000)};

	dibp_blend #(.DB(DB), .SW(SIDE2)) u_blend (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(w_vld),
		.weight(w_q), .sample(b_smp), .present(b_pres), .scale(scale_eff),
		.side_in(b_side_in), .out_valid(b_vld), .dividend(z_num), .divisor(z_den),
		.side_out(b_side_out)
	);

	// depth divider
	logic [0:0][ZNW-1:0]  z_num_l;
	logic [0:0][DENW-1:0] z_den_l;
	logic [0:0][OW-1:0]   z_q;
	logic [SIDE2-1:0]     z_side_out;
	logic                 z_vld;
	assign z_num_l[0] = z_num;
	assign z_den_l[0] = z_den;

	dibp_div #(
		.LANES(1), .NW(ZNW), .DW(DENW), .QW(OW), .SW(SIDE2)
	) u_zdiv (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(b_vld),
		.dividend(z_num_l), .divisor(z_den_l), .side_in(b_side_out),
		.out_valid(z_vld), .quotient(z_q), .side_out(z_side_out)
	);

	// stage P: offset times depth plus half the focal length
	logic               nx_p, ny_p, nd_p;
	logic [PW_-1:0]     dx_p, dy_p;
	assign {nx_p, dx_p, ny_p, dy_p, nd_p} = z_side_out;

	logic               vld_p_s1;
	logic [1:0][NXW-1:0] pn_p_s1;
	logic [OW-1:0]      z_p_s1;
	logic               nx_p_s1, ny_p_s1, nd_p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_p_s1 <= 1'b0;
		end else if (adv) begin
			vld_p_s1 <= z_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pn_p_s1[0] <= NXW'(dx_p) * NXW'(z_q[0]) + NXW'(fx_eff >> 1);
			pn_p_s1[1] <= NXW'(dy_p) * NXW'(z_q[0]) + NXW'(fy_eff >> 1);
			z_p_s1     <= z_q[0];
			nx_p_s1    <= nx_p;
			ny_p_s1    <= ny_p;
			nd_p_s1    <= nd_p;
		end
	end

	// X/Y divider; a high part at or above the focal length saturates
	logic [1:0][PW_-1:0] xy_den;
	logic [1:0][OW-1:0]  xy_q;
	logic                ovx, ovy;
	logic [SIDE3-1:0]    xy_side_in, xy_side_out;
	logic                xy_vld;
	assign xy_den[0]  = fx_eff;
	assign xy_den[1]  = fy_eff;
	assign ovx        = pn_p_s1[0][NXW-1:OW] >= (PW_+1)'(fx_eff);
	assign ovy        = pn_p_s1[1][NXW-1:OW] >= (PW_+1)'(fy_eff);
	assign xy_side_in = {z_p_s1, nx_p_s1, ovx, ny_p_s1, ovy, nd_p_s1};

	dibp_div #(
		.LANES(2), .NW(NXW), .DW(PW_), .QW(OW), .SW(SIDE3)
	) u_xydiv (
		.clk(clk), .arst_n(arst_n), .en(adv), .in_valid(vld_p_s1),
		.dividend(pn_p_s1), .divisor(xy_den), .side_in(xy_side_in),
		.out_valid(xy_vld), .quotient(xy_q), .side_out(xy_side_out)
	);

	// apply sign and saturate
	logic [OW-1:0] zo;
	logic          nxo, ovxo, nyo, ovyo, ndo;
	logic [OW-1:0] xo, yo;
	assign {zo, nxo, ovxo, nyo, ovyo, ndo} = xy_side_out;

	always_comb begin
		if (nxo) begin
			xo = (ovxo || xy_q[0] > NEG_MAX) ? NEG_MAX : OW'(0) - xy_q[0];
		end else begin
			xo = (ovxo || xy_q[0] > POS_MAX) ? POS_MAX : xy_q[0];
		end
		if (nyo) begin
			yo = (ovyo || xy_q[1] > NEG_MAX) ? NEG_MAX : OW'(0) - xy_q[1];
		end else begin
			yo = (ovyo || xy_q[1] > POS_MAX) ? POS_MAX : xy_q[1];
		end
	end

	// output register; hold while the beat is not taken
	logic [95:0] m_data_q;
	logic        m_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= xy_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_data_q <= ndo ? '0 : {zo, yo, xo};
			m_user_q <= ndo;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule
